### rtl/hfpa_pkg.sv
// Shared types and constants for the heap file page allocator.
// Used by heap_file_page_allocator and hfpa_alu; depends on nothing.

package hfpa_pkg;

    localparam int MAX_PAGES_DEF      = 16;
    localparam int SLOTS_PER_PAGE_DEF = 64;

    localparam logic [15:0] PAGE_BYTES_RESET = 16'd4096;
    localparam logic [31:0] HDR_BYTES        = 32'd16;
    localparam logic [16:0] REC_OVERHEAD     = 17'd4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        record_size;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status_code;
        logic       is_total;
        logic [3:0] page_index;
        logic [5:0] slot_index;
        logic [6:0] count;
        logic       last;
    } result_t;

    typedef struct packed {
        logic        ge;
        logic        eq;
        logic [31:0] diff;
    } alu_res_t;

endpackage

### rtl/heap_file_page_allocator.sv
// Heap file page allocator: first-fit record placement, value search and status report.
// A command is taken when start is high and busy is low. Insert reads and checks each
// page tried, appends a page when none fits or reports full, then writes; search reads
// and checks each page, then reads and compares each of its records; status reads and
// reports each page. The page table and the record store are memories with one
// registered read port each, and a single compare and subtract unit does every fit
// check, header deduction, space update and value match. Results appear one per cycle
// at most on result with result_strobe for one cycle and cannot be held off. Configuration
// writes are taken only while idle and apply to pages appended afterwards. No clearing
// pass after reset. Depends on hfpa_pkg, hfpa_ram and hfpa_alu.

module heap_file_page_allocator
    import hfpa_pkg::*;
#(
    parameter int MAX_PAGES      = MAX_PAGES_DEF,
    parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output result_t     result,
    output logic        result_strobe
);

    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int SW  = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int CW  = $clog2(SLOTS_PER_PAGE + 1);
    localparam int RD  = MAX_PAGES * SLOTS_PER_PAGE;
    localparam int AW  = (RD > 1) ? $clog2(RD) : 1;
    localparam int TW  = 16 + CW;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_INS_RD    = 11'b000_0000_0010,
        S_INS_CHK   = 11'b000_0000_0100,
        S_INS_NEW   = 11'b000_0000_1000,
        S_INS_WR    = 11'b000_0001_0000,
        S_SRCH_PG   = 11'b000_0010_0000,
        S_SRCH_PCHK = 11'b000_0100_0000,
        S_SRCH_RD   = 11'b000_1000_0000,
        S_SRCH_CHK  = 11'b001_0000_0000,
        S_STAT_RD   = 11'b010_0000_0000,
        S_STAT_OUT  = 11'b100_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [PCW-1:0]  page_count_reg, page_count_next;
    logic [15:0]     page_bytes_reg;
    logic [PW-1:0]   scan_page_reg, scan_page_next;
    logic [PW-1:0]   target_reg, target_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [CW-1:0]   lim_reg, lim_next;
    logic [16:0]     need_reg, need_next;
    logic [31:0]     val_reg, val_next;
    logic [15:0]     free_base_reg, free_base_next;
    logic [AW-1:0]   rec_addr_reg, rec_addr_next;
    result_t         result_reg, result_next;
    logic            strobe_reg, strobe_next;

    logic            page_we;
    logic [TW-1:0]   page_wdata;
    logic [TW-1:0]   page_rdata;
    logic            rec_we;
    logic [AW-1:0]   rec_waddr;
    logic [31:0]     rec_rdata;
    logic [15:0]     rd_free;
    logic [CW-1:0]   rd_cnt;
    logic            scan_at_end;
    logic [31:0]     alu_a;
    logic [31:0]     alu_b;
    alu_res_t        alu;

    hfpa_ram #(
        .DEPTH (MAX_PAGES),
        .WIDTH (TW),
        .AW    (PW)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (target_reg),
        .wdata (page_wdata),
        .raddr (scan_page_reg),
        .rdata (page_rdata)
    );

    hfpa_ram #(
        .DEPTH (RD),
        .WIDTH (32),
        .AW    (AW)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (val_reg),
        .raddr (rec_addr_reg),
        .rdata (rec_rdata)
    );

    hfpa_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu)
    );

    assign rd_free       = page_rdata[CW +: 16];
    assign rd_cnt        = page_rdata[CW-1:0];
    assign scan_at_end   = ((PCW'(scan_page_reg) + PCW'(1)) == page_count_reg);
    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;
    assign page_wdata    = {alu.diff[15:0], CW'(slot_reg) + CW'(1)};
    assign rec_waddr     = AW'(32'(target_reg) * 32'(SLOTS_PER_PAGE) + 32'(slot_reg));

    always_comb
    begin
        unique case (state_reg)
            S_INS_CHK:
            begin
                alu_a = 32'(rd_free);
                alu_b = 32'(need_reg);
            end
            S_INS_NEW:
            begin
                alu_a = 32'(page_bytes_reg);
                alu_b = HDR_BYTES;
            end
            S_INS_WR:
            begin
                alu_a = 32'(free_base_reg);
                alu_b = 32'(need_reg);
            end
            S_SRCH_CHK:
            begin
                alu_a = rec_rdata;
                alu_b = val_reg;
            end
            default:
            begin
                alu_a = 32'd0;
                alu_b = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        page_count_next = page_count_reg;
        scan_page_next  = scan_page_reg;
        target_next     = target_reg;
        slot_next       = slot_reg;
        lim_next        = lim_reg;
        need_next       = need_reg;
        val_next        = val_reg;
        free_base_next  = free_base_reg;
        rec_addr_next   = rec_addr_reg;
        result_next     = '0;
        strobe_next     = 1'b0;
        page_we         = 1'b0;
        rec_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            need_next      = 17'(cmd.record_size) + REC_OVERHEAD;
                            val_next       = cmd.value;
                            scan_page_next = '0;
                            state_next     = (page_count_reg == '0) ? S_INS_NEW : S_INS_RD;
                        end
                        OP_SEARCH:
                        begin
                            val_next       = cmd.value;
                            scan_page_next = '0;
                            if (page_count_reg == '0)
                            begin
                                result_next.status_code = ST_MISS;
                                result_next.last        = 1'b1;
                                strobe_next             = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SRCH_PG;
                            end
                        end
                        OP_STATUS:
                        begin
                            scan_page_next       = '0;
                            result_next.is_total = 1'b1;
                            result_next.count    = 7'(32'(page_count_reg));
                            result_next.last     = (page_count_reg == '0);
                            strobe_next          = 1'b1;
                            if (page_count_reg != '0)
                            begin
                                state_next = S_STAT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                if (alu.ge && (rd_cnt < CW'(SLOTS_PER_PAGE)))
                begin
                    target_next    = scan_page_reg;
                    slot_next      = SW'(rd_cnt);
                    free_base_next = rd_free;
                    state_next     = S_INS_WR;
                end
                else if (scan_at_end)
                begin
                    state_next = S_INS_NEW;
                end
                else
                begin
                    scan_page_next = scan_page_reg + PW'(1);
                    state_next     = S_INS_RD;
                end
            end
            S_INS_NEW:
            begin
                if (page_count_reg == PCW'(MAX_PAGES))
                begin
                    result_next.status_code = ST_FULL;
                    result_next.last        = 1'b1;
                    strobe_next             = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    target_next     = PW'(page_count_reg);
                    slot_next       = '0;
                    free_base_next  = alu.diff[15:0];
                    page_count_next = page_count_reg + PCW'(1);
                    state_next      = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                page_we                = 1'b1;
                rec_we                 = 1'b1;
                result_next.status_code = ST_OK;
                result_next.page_index = 4'(32'(target_reg));
                result_next.slot_index = 6'(32'(slot_reg));
                result_next.last       = 1'b1;
                strobe_next            = 1'b1;
                state_next             = S_IDLE;
            end
            S_SRCH_PG:
            begin
                state_next = S_SRCH_PCHK;
            end
            S_SRCH_PCHK:
            begin
                lim_next      = rd_cnt;
                slot_next     = '0;
                rec_addr_next = AW'(32'(scan_page_reg) * 32'(SLOTS_PER_PAGE));
                if (rd_cnt != '0)
                begin
                    state_next = S_SRCH_RD;
                end
                else if (scan_at_end)
                begin
                    result_next.status_code = ST_MISS;
                    result_next.last        = 1'b1;
                    strobe_next             = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    scan_page_next = scan_page_reg + PW'(1);
                    state_next     = S_SRCH_PG;
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (alu.eq)
                begin
                    result_next.status_code = ST_OK;
                    result_next.page_index  = 4'(32'(scan_page_reg));
                    result_next.slot_index  = 6'(32'(slot_reg));
                    result_next.last        = 1'b1;
                    strobe_next             = 1'b1;
                    state_next              = S_IDLE;
                end
                else if ((CW'(slot_reg) + CW'(1)) != lim_reg)
                begin
                    slot_next     = slot_reg + SW'(1);
                    rec_addr_next = rec_addr_reg + AW'(1);
                    state_next    = S_SRCH_RD;
                end
                else if (scan_at_end)
                begin
                    result_next.status_code = ST_MISS;
                    result_next.last        = 1'b1;
                    strobe_next             = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    scan_page_next = scan_page_reg + PW'(1);
                    state_next     = S_SRCH_PG;
                end
            end
            S_STAT_RD:
            begin
                state_next = S_STAT_OUT;
            end
            S_STAT_OUT:
            begin
                result_next.page_index = 4'(32'(scan_page_reg));
                result_next.count      = 7'(32'(rd_cnt));
                result_next.last       = scan_at_end;
                strobe_next            = 1'b1;
                if (scan_at_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_page_next = scan_page_reg + PW'(1);
                    state_next     = S_STAT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            page_count_reg <= '0;
            page_bytes_reg <= PAGE_BYTES_RESET;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            page_count_reg <= page_count_next;
            strobe_reg     <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                page_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_page_reg <= scan_page_next;
        target_reg    <= target_next;
        slot_reg      <= slot_next;
        lim_reg       <= lim_next;
        need_reg      <= need_next;
        val_reg       <= val_next;
        free_base_reg <= free_base_next;
        rec_addr_reg  <= rec_addr_next;
        result_reg    <= result_next;
    end

    a_page_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        page_count_reg <= PCW'(MAX_PAGES))
        else $error("page count beyond capacity");

    a_last_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last) |-> (state_reg == S_IDLE))
        else $error("final result while still working");

    a_grow_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        (page_count_reg != $past(page_count_reg)) |-> ($past(state_reg) == S_INS_NEW))
        else $error("page count changed outside append");

    a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (result_reg.status_code == ST_FULL))
            |-> (page_count_reg == PCW'(MAX_PAGES)))
        else $error("store full reported below capacity");

endmodule

### rtl/hfpa_ram.sv
// Single-port-write, registered-read memory for the allocator tables.
// Depends on nothing; instantiated by heap_file_page_allocator.

module hfpa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/hfpa_alu.sv
// Shared compare and saturating-subtract unit of the allocator.
// Depends on hfpa_pkg for its result struct.

module hfpa_alu
    import hfpa_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output alu_res_t    res
);

    always_comb
    begin
        res.ge   = (a >= b);
        res.eq   = (a == b);
        res.diff = (a >= b) ? (a - b) : 32'd0;
    end

endmodule
